[hw/rtl/ptmd_pkg.sv]
// Shared types, widths and constants for the point/triangle distance unit.
// No dependencies; imported by every other file of the block.
`default_nettype none

package ptmd_pkg;

    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int EDGE_W        = 15;
    localparam int EDGE_LIM_BITS = 14;
    localparam int DE_LIM_BITS   = 31;
    localparam int PBITS         = 28;
    localparam int PARAM_W       = PBITS + 1;
    localparam int WIDE_W        = 64;
    localparam int MUL_W         = 34;
    localparam int SHIFT_W       = 6;
    localparam int LEN_W         = 7;
    localparam int STEP_W        = 5;
    localparam int ROOT_STEPS    = 32;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 3'd3;

    localparam logic [COORD_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PBITS;

    localparam logic OP_RATIO = 1'b0;
    localparam logic OP_SQRT  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic [PARAM_W-1:0]        param_t;

    typedef struct packed {
        logic start;
        logic op;
    } ds_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

    // number of significant bits of an unsigned word
    function automatic logic [LEN_W-1:0] bit_len(input logic [WIDE_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < WIDE_W; i++)
        begin
            if (v[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ptmd_if.sv]
// Valid/ready channel interfaces for triangle beats and result beats.
// Depends on ptmd_pkg.
`default_nettype none

interface ptmd_tri_if import ptmd_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic   last_triangle;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                    input ready);
    modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_triangle,
                  output ready);
endinterface

interface ptmd_res_if import ptmd_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t min_distance;
    logic   degenerate_seen;

    modport source (output valid, min_distance, degenerate_seen, input ready);
    modport sink (input valid, min_distance, degenerate_seen, output ready);
endinterface

`default_nettype wire

[hw/rtl/ptmd_div_sqrt.sv]
// Iterative unit: clamped Q1.28 ratio (one quotient bit per cycle) and
// integer square root (one result bit per cycle). Depends on ptmd_pkg.
`default_nettype none

module ptmd_div_sqrt
    import ptmd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ds_ctrl_t          ctrl,
    input  wide_t             num,
    input  wide_t             den,
    output ds_stat_t          stat,
    output logic [WIDE_W-1:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              op_reg, op_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WIDE_W:0]   rem_reg, rem_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    logic [WIDE_W-1:0] res_reg, res_next;
    logic [WIDE_W:0]   rem_sh;
    logic [LEN_W-1:0]  bit_pos;
    logic [WIDE_W-1:0] bitv;
    logic [WIDE_W-1:0] trial;
    logic [STEP_W-1:0] last_cnt;

    assign rem_sh   = {rem_reg[WIDE_W-1:0], 1'b0};
    assign bit_pos  = LEN_W'(WIDE_W - 2) - {1'b0, cnt_reg, 1'b0};
    assign bitv     = WIDE_W'(1) << bit_pos;
    assign trial    = res_reg + bitv;
    assign last_cnt = (op_reg == OP_SQRT) ? STEP_W'(ROOT_STEPS - 1) : STEP_W'(PBITS - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        res_next  = res_reg;
        if (ctrl.start)
        begin
            op_next  = ctrl.op;
            cnt_next = '0;
            den_next = den;
            res_next = '0;
            rem_next = {1'b0, num};
            if (ctrl.op == OP_SQRT)
            begin
                busy_next = 1'b1;
            end
            else if (num <= 64'sd0)
            begin
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                res_next  = WIDE_W'(PARAM_ONE);
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_RATIO)
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    res_next = {res_reg[WIDE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    res_next = {res_reg[WIDE_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (rem_reg[WIDE_W-1:0] >= trial)
                begin
                    rem_next = {1'b0, rem_reg[WIDE_W-1:0] - trial};
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == last_cnt)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_RATIO;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

[hw/rtl/point_triangle_min_distance_unit.sv]
// Point to triangle distance over a triangle stream, keeping the least magnitude.
// Depends on ptmd_pkg, ptmd_if and ptmd_div_sqrt.
//
// One triangle beat is taken at a time. The time per triangle is set by one shared
// 34x34 multiply-accumulate stepping through 30 products (39 in signed mode) and by
// the bit-serial divider/square-root unit: one ratio (two in the interior case, and a
// ratio that clamps to 0 or 1 is settled without iterating) and then the root. A
// degenerate triangle stops after its determinant. A result beat follows only a beat
// with last_triangle set; while an earlier result is still pending the unit waits at
// the end of that triangle.
`default_nettype none

module point_triangle_min_distance_unit
    import ptmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    ptmd_tri_if.sink             triangle,
    ptmd_res_if.source           result
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_EDGE    = 5'd1;
    localparam logic [4:0] S_A       = 5'd2;
    localparam logic [4:0] S_B       = 5'd3;
    localparam logic [4:0] S_C       = 5'd4;
    localparam logic [4:0] S_DET0    = 5'd5;
    localparam logic [4:0] S_DET1    = 5'd6;
    localparam logic [4:0] S_D       = 5'd7;
    localparam logic [4:0] S_E       = 5'd8;
    localparam logic [4:0] S_KD      = 5'd9;
    localparam logic [4:0] S_S0      = 5'd10;
    localparam logic [4:0] S_S1      = 5'd11;
    localparam logic [4:0] S_T0      = 5'd12;
    localparam logic [4:0] S_T1      = 5'd13;
    localparam logic [4:0] S_REG     = 5'd14;
    localparam logic [4:0] S_DIV1    = 5'd15;
    localparam logic [4:0] S_DIV2    = 5'd16;
    localparam logic [4:0] S_PARAM   = 5'd17;
    localparam logic [4:0] S_OFF0    = 5'd18;
    localparam logic [4:0] S_OFF1    = 5'd19;
    localparam logic [4:0] S_SQ      = 5'd20;
    localparam logic [4:0] S_ROOT_GO = 5'd21;
    localparam logic [4:0] S_ROOT    = 5'd22;
    localparam logic [4:0] S_N0      = 5'd23;
    localparam logic [4:0] S_N1      = 5'd24;
    localparam logic [4:0] S_N2      = 5'd25;
    localparam logic [4:0] S_UPD     = 5'd26;
    localparam logic [4:0] S_FIN     = 5'd27;

    localparam logic [2:0] SEL_ZERO   = 3'd0;
    localparam logic [2:0] SEL_ONE    = 3'd1;
    localparam logic [2:0] SEL_Q1     = 3'd2;
    localparam logic [2:0] SEL_ONE_Q1 = 3'd3;
    localparam logic [2:0] SEL_Q2     = 3'd4;

    function automatic param_t pick(input logic [2:0] sel, input param_t q1, input param_t q2);
        param_t p;
        unique case (sel)
            SEL_ONE:    p = PARAM_ONE;
            SEL_Q1:     p = q1;
            SEL_ONE_Q1: p = PARAM_ONE - q1;
            SEL_Q2:     p = q2;
            default:    p = '0;
        endcase
        return p;
    endfunction

    // configuration
    coord_t qx_reg, qy_reg, qz_reg;
    logic   smode_reg;

    // control
    logic [4:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       fin_load;
    logic       tri_acc;

    // datapath
    diff_t  ed0_reg [3];
    diff_t  ed1_reg [3];
    diff_t  dq_reg [3];
    edge_t  e0_reg [3];
    edge_t  e1_reg [3];
    logic   last_reg;
    logic [SHIFT_W-1:0] ke_reg, kd_reg;
    wide_t  acc_reg, a_reg, b_reg, c_reg, det_reg, d_reg, e_reg, lim_reg;
    wide_t  s_reg, t_reg, n2_reg, d2_reg, diff_reg, sq_reg, n_reg, dot_reg;
    coord_t ds_reg, es_reg, dist_reg, best_reg, best_next;
    logic   flag_reg, flag_next;
    logic   sat_reg;
    param_t q1_reg, q2_reg, sp_reg, tp_reg;
    logic [2:0] sp_sel_reg, tp_sel_reg, sp_sel, tp_sel;
    logic   need2_reg, need2;
    coord_t out_dist_reg;
    logic   out_flag_reg;

    // per-item selections
    edge_t  e0_i, e1_i, e0_j1, e0_j2, e1_j1, e1_j2;
    diff_t  ed0_i, ed1_i, dq_i;

    // multiply-accumulate
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    wide_t prod64, mac_out;

    // edge shift and region
    logic [DIFF_W-1:0] m_abs [6];
    logic [DIFF_W-1:0] m_max;
    logic [LEN_W-1:0]  m_len, md_len;
    logic [SHIFT_W-1:0] ke_val, kd_val;
    logic [WIDE_W-1:0] d_abs, e_abs, md;
    wide_t st, den2, t0, t1, n1, d1, n2, off_r, diff_val;
    logic  diff_big;
    coord_t dist_f;
    logic [COORD_W-1:0] best_abs, dist_abs;

    // divider/sqrt
    ds_ctrl_t ds_ctrl;
    ds_stat_t ds_stat;
    wide_t    ds_num, ds_den;
    logic [WIDE_W-1:0] ds_result;
    coord_t   root_dist;

    assign tri_acc        = triangle.valid && triangle.ready;
    assign triangle.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg    <= '0;
            qy_reg    <= '0;
            qz_reg    <= '0;
            smode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUERY_X:     qx_reg    <= coord_t'(cfg_data);
                REG_QUERY_Y:     qy_reg    <= coord_t'(cfg_data);
                REG_QUERY_Z:     qz_reg    <= coord_t'(cfg_data);
                REG_SIGNED_MODE: smode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            2'd1:
            begin
                e0_i = e0_reg[1]; e1_i = e1_reg[1];
                ed0_i = ed0_reg[1]; ed1_i = ed1_reg[1]; dq_i = dq_reg[1];
                e0_j1 = e0_reg[2]; e1_j1 = e1_reg[2];
                e0_j2 = e0_reg[0]; e1_j2 = e1_reg[0];
            end
            2'd2:
            begin
                e0_i = e0_reg[2]; e1_i = e1_reg[2];
                ed0_i = ed0_reg[2]; ed1_i = ed1_reg[2]; dq_i = dq_reg[2];
                e0_j1 = e0_reg[0]; e1_j1 = e1_reg[0];
                e0_j2 = e0_reg[1]; e1_j2 = e1_reg[1];
            end
            default:
            begin
                e0_i = e0_reg[0]; e1_i = e1_reg[0];
                ed0_i = ed0_reg[0]; ed1_i = ed1_reg[0]; dq_i = dq_reg[0];
                e0_j1 = e0_reg[1]; e1_j1 = e1_reg[1];
                e0_j2 = e0_reg[2]; e1_j2 = e1_reg[2];
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_A:    begin mul_a = MUL_W'(e0_i);    mul_b = MUL_W'(e0_i);    end
            S_B:    begin mul_a = MUL_W'(e0_i);    mul_b = MUL_W'(e1_i);    end
            S_C:    begin mul_a = MUL_W'(e1_i);    mul_b = MUL_W'(e1_i);    end
            S_DET0: begin mul_a = MUL_W'(a_reg);   mul_b = MUL_W'(c_reg);   end
            S_DET1: begin mul_a = MUL_W'(b_reg);   mul_b = MUL_W'(b_reg);   end
            S_D:    begin mul_a = MUL_W'(e0_i);    mul_b = MUL_W'(dq_i);    end
            S_E:    begin mul_a = MUL_W'(e1_i);    mul_b = MUL_W'(dq_i);    end
            S_S0:   begin mul_a = MUL_W'(b_reg);   mul_b = MUL_W'(es_reg);  end
            S_S1:   begin mul_a = MUL_W'(c_reg);   mul_b = MUL_W'(ds_reg);  end
            S_T0:   begin mul_a = MUL_W'(b_reg);   mul_b = MUL_W'(ds_reg);  end
            S_T1:   begin mul_a = MUL_W'(a_reg);   mul_b = MUL_W'(es_reg);  end
            S_OFF0: begin mul_a = MUL_W'(sp_reg);  mul_b = MUL_W'(ed0_i);   end
            S_OFF1: begin mul_a = MUL_W'(tp_reg);  mul_b = MUL_W'(ed1_i);   end
            S_SQ:   begin mul_a = MUL_W'(diff_reg); mul_b = MUL_W'(diff_reg); end
            S_N0:   begin mul_a = MUL_W'(e0_j1);   mul_b = MUL_W'(e1_j2);   end
            S_N1:   begin mul_a = MUL_W'(e0_j2);   mul_b = MUL_W'(e1_j1);   end
            S_N2:   begin mul_a = MUL_W'(n_reg);   mul_b = MUL_W'(dq_i);    end
            default: ;
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod64 = wide_t'(prod[WIDE_W-1:0]);

    always_comb
    begin
        unique case (state_reg)
            S_A, S_B, S_C, S_D, S_E:
                mac_out = ((idx_reg == 2'd0) ? wide_t'(0) : acc_reg) + prod64;
            S_DET1, S_S1, S_T1, S_N1: mac_out = acc_reg - prod64;
            S_OFF1:                   mac_out = acc_reg + prod64;
            S_SQ:                     mac_out = sq_reg + prod64;
            S_N2:                     mac_out = dot_reg + prod64;
            default:                  mac_out = prod64;
        endcase
    end

    // edge scaling
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_abs[i]     = ed0_reg[i][DIFF_W-1] ? DIFF_W'(-ed0_reg[i]) : DIFF_W'(ed0_reg[i]);
            m_abs[i + 3] = ed1_reg[i][DIFF_W-1] ? DIFF_W'(-ed1_reg[i]) : DIFF_W'(ed1_reg[i]);
        end
        m_max = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (m_abs[i] > m_max)
            begin
                m_max = m_abs[i];
            end
        end
    end

    assign m_len  = bit_len(WIDE_W'(m_max));
    assign ke_val = (m_len > LEN_W'(EDGE_LIM_BITS)) ? SHIFT_W'(m_len - LEN_W'(EDGE_LIM_BITS)) : '0;

    assign d_abs  = d_reg[WIDE_W-1] ? WIDE_W'(-d_reg) : WIDE_W'(d_reg);
    assign e_abs  = e_reg[WIDE_W-1] ? WIDE_W'(-e_reg) : WIDE_W'(e_reg);
    assign md     = (d_abs > e_abs) ? d_abs : e_abs;
    assign md_len = bit_len(md);
    assign kd_val = (md_len > LEN_W'(DE_LIM_BITS)) ? SHIFT_W'(md_len - LEN_W'(DE_LIM_BITS)) : '0;

    // region choice and clamp setup
    always_comb
    begin
        st     = s_reg + t_reg;
        den2   = a_reg - (b_reg <<< 1) + c_reg;
        t0     = '0;
        t1     = '0;
        n1     = -d_reg;
        d1     = a_reg;
        n2     = t_reg <<< kd_reg;
        sp_sel = SEL_Q1;
        tp_sel = SEL_ZERO;
        need2  = 1'b0;
        if (st <= lim_reg)
        begin
            if (s_reg < 0 && t_reg < 0)
            begin
                if (d_reg >= 0)
                begin
                    sp_sel = SEL_ZERO; tp_sel = SEL_Q1; n1 = -e_reg; d1 = c_reg;
                end
            end
            else if (s_reg < 0)
            begin
                sp_sel = SEL_ZERO; tp_sel = SEL_Q1; n1 = -e_reg; d1 = c_reg;
            end
            else if (t_reg >= 0)
            begin
                n1 = s_reg <<< kd_reg; d1 = det_reg; tp_sel = SEL_Q2; need2 = 1'b1;
            end
        end
        else if (s_reg < 0)
        begin
            t0 = b_reg + d_reg;
            t1 = c_reg + e_reg;
            if (t1 > t0)
            begin
                n1 = t1 - t0; d1 = den2; tp_sel = SEL_ONE_Q1;
            end
            else
            begin
                sp_sel = SEL_ZERO; n1 = -e_reg; d1 = c_reg;
                tp_sel = (t1 <= 0) ? SEL_ONE : SEL_Q1;
            end
        end
        else if (t_reg < 0)
        begin
            t0 = b_reg + e_reg;
            t1 = a_reg + d_reg;
            if (t1 > t0)
            begin
                n1 = t1 - t0; d1 = den2; tp_sel = SEL_Q1; sp_sel = SEL_ONE_Q1;
            end
            else
            begin
                tp_sel = SEL_ZERO; sp_sel = (t1 <= 0) ? SEL_ONE : SEL_Q1;
            end
        end
        else
        begin
            n1 = c_reg + e_reg - b_reg - d_reg; d1 = den2; tp_sel = SEL_ONE_Q1;
        end
    end

    assign off_r    = (mac_out + (wide_t'(1) <<< (PBITS - 1))) >>> PBITS;
    assign diff_val = wide_t'(dq_i) + off_r;
    assign diff_big = (diff_reg >= (wide_t'(1) <<< DE_LIM_BITS))
                   || (diff_reg <= -(wide_t'(1) <<< DE_LIM_BITS));

    assign root_dist = (sat_reg || ds_result > WIDE_W'(DIST_MAX))
                     ? coord_t'(DIST_MAX) : coord_t'(ds_result[COORD_W-1:0]);
    assign dist_f    = (smode_reg && dot_reg < 0) ? -dist_reg : dist_reg;
    assign best_abs  = best_reg[COORD_W-1] ? COORD_W'(-best_reg) : COORD_W'(best_reg);
    assign dist_abs  = dist_f[COORD_W-1] ? COORD_W'(-dist_f) : COORD_W'(dist_f);

    // divider/sqrt control
    always_comb
    begin
        ds_ctrl.start = 1'b0;
        ds_ctrl.op    = OP_RATIO;
        ds_num        = n2_reg;
        ds_den        = d2_reg;
        unique case (state_reg)
            S_REG:
            begin
                ds_ctrl.start = 1'b1;
                ds_num        = n1;
                ds_den        = d1;
            end
            S_DIV1:  ds_ctrl.start = ds_stat.done && need2_reg;
            S_ROOT_GO:
            begin
                ds_ctrl.start = 1'b1;
                ds_ctrl.op    = OP_SQRT;
                ds_num        = sq_reg;
            end
            default: ;
        endcase
    end

    ptmd_div_sqrt u_div_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ds_ctrl),
        .num    (ds_num),
        .den    (ds_den),
        .stat   (ds_stat),
        .result (ds_result)
    );

    // sequencer
    assign fin_load = (state_reg == S_FIN) && last_reg && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        flag_next      = flag_reg;
        out_valid_next = fin_load || (out_valid_reg && !result.ready);
        unique case (state_reg)
            S_IDLE:
            begin
                if (tri_acc)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:  begin state_next = S_A; idx_next = '0; end
            S_A, S_B, S_C, S_D, S_E:
            begin
                if (idx_reg == 2'd2)
                begin
                    idx_next = '0;
                    unique case (state_reg)
                        S_A:     state_next = S_B;
                        S_B:     state_next = S_C;
                        S_C:     state_next = S_DET0;
                        S_D:     state_next = S_E;
                        default: state_next = S_KD;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_DET0:  state_next = S_DET1;
            S_DET1:
            begin
                if (mac_out == 0)
                begin
                    flag_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_D;
                end
            end
            S_KD:    state_next = S_S0;
            S_S0:    state_next = S_S1;
            S_S1:    state_next = S_T0;
            S_T0:    state_next = S_T1;
            S_T1:    state_next = S_REG;
            S_REG:   state_next = S_DIV1;
            S_DIV1:
            begin
                if (ds_stat.done)
                begin
                    state_next = need2_reg ? S_DIV2 : S_PARAM;
                end
            end
            S_DIV2:
            begin
                if (ds_stat.done)
                begin
                    state_next = S_PARAM;
                end
            end
            S_PARAM: begin state_next = S_OFF0; idx_next = '0; end
            S_OFF0:  state_next = S_OFF1;
            S_OFF1:  state_next = S_SQ;
            S_SQ:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = S_ROOT_GO;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = S_OFF0;
                    idx_next   = idx_reg + 2'd1;
                end
            end
            S_ROOT_GO: state_next = S_ROOT;
            S_ROOT:
            begin
                if (ds_stat.done)
                begin
                    state_next = smode_reg ? S_N0 : S_UPD;
                    idx_next   = '0;
                end
            end
            S_N0:    state_next = S_N1;
            S_N1:    state_next = S_N2;
            S_N2:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = S_UPD;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = S_N0;
                    idx_next   = idx_reg + 2'd1;
                end
            end
            S_UPD:
            begin
                if (best_abs > dist_abs)
                begin
                    best_next = dist_f;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (fin_load)
                begin
                    best_next  = coord_t'(DIST_MAX);
                    flag_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            best_reg      <= coord_t'(DIST_MAX);
            flag_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            best_reg      <= best_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (tri_acc)
                begin
                    ed0_reg[0] <= diff_t'(triangle.bx) - diff_t'(triangle.ax);
                    ed0_reg[1] <= diff_t'(triangle.by) - diff_t'(triangle.ay);
                    ed0_reg[2] <= diff_t'(triangle.bz) - diff_t'(triangle.az);
                    ed1_reg[0] <= diff_t'(triangle.cx) - diff_t'(triangle.ax);
                    ed1_reg[1] <= diff_t'(triangle.cy) - diff_t'(triangle.ay);
                    ed1_reg[2] <= diff_t'(triangle.cz) - diff_t'(triangle.az);
                    dq_reg[0]  <= diff_t'(triangle.ax) - diff_t'(qx_reg);
                    dq_reg[1]  <= diff_t'(triangle.ay) - diff_t'(qy_reg);
                    dq_reg[2]  <= diff_t'(triangle.az) - diff_t'(qz_reg);
                    last_reg   <= triangle.last_triangle;
                end
            end
            S_EDGE:
            begin
                ke_reg <= ke_val;
                for (int i = 0; i < 3; i++)
                begin
                    e0_reg[i] <= EDGE_W'(ed0_reg[i] >>> ke_val);
                    e1_reg[i] <= EDGE_W'(ed1_reg[i] >>> ke_val);
                end
            end
            S_A, S_B, S_C, S_D, S_E:
            begin
                acc_reg <= mac_out;
                if (idx_reg == 2'd2)
                begin
                    unique case (state_reg)
                        S_A:     a_reg <= mac_out;
                        S_B:     b_reg <= mac_out;
                        S_C:     c_reg <= mac_out;
                        S_D:     d_reg <= mac_out >>> ke_reg;
                        default: e_reg <= mac_out >>> ke_reg;
                    endcase
                end
            end
            S_DET1:  det_reg <= mac_out;
            S_KD:
            begin
                kd_reg  <= kd_val;
                ds_reg  <= COORD_W'(d_reg >>> kd_val);
                es_reg  <= COORD_W'(e_reg >>> kd_val);
                lim_reg <= det_reg >>> kd_val;
            end
            S_S1:    s_reg <= mac_out;
            S_T1:    t_reg <= mac_out;
            S_REG:
            begin
                sp_sel_reg <= sp_sel;
                tp_sel_reg <= tp_sel;
                need2_reg  <= need2;
                n2_reg     <= n2;
                d2_reg     <= det_reg;
            end
            S_DIV1:
            begin
                if (ds_stat.done)
                begin
                    q1_reg <= ds_result[PARAM_W-1:0];
                end
            end
            S_DIV2:
            begin
                if (ds_stat.done)
                begin
                    q2_reg <= ds_result[PARAM_W-1:0];
                end
            end
            S_PARAM:
            begin
                sp_reg  <= pick(sp_sel_reg, q1_reg, q2_reg);
                tp_reg  <= pick(tp_sel_reg, q1_reg, q2_reg);
                sq_reg  <= '0;
                sat_reg <= 1'b0;
            end
            S_OFF1:  diff_reg <= diff_val;
            S_SQ:
            begin
                if (diff_big)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    sq_reg <= mac_out;
                end
            end
            S_ROOT:
            begin
                dist_reg <= root_dist;
                dot_reg  <= '0;
            end
            S_N1:    n_reg   <= mac_out;
            S_N2:    dot_reg <= mac_out;
            S_FIN:
            begin
                if (fin_load)
                begin
                    out_dist_reg <= best_reg;
                    out_flag_reg <= flag_reg;
                end
            end
            default:
            begin
                acc_reg <= mac_out;
            end
        endcase
    end

    assign result.valid           = out_valid_reg;
    assign result.min_distance    = out_dist_reg;
    assign result.degenerate_seen = out_flag_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ds_ctrl.start |-> !ds_stat.busy)
        else $error("div/sqrt started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        ds_stat.done |-> (state_reg == S_DIV1 || state_reg == S_DIV2 || state_reg == S_ROOT))
        else $error("div/sqrt finished with no one waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (best_reg == coord_t'(DIST_MAX) && !flag_reg))
        else $error("scan state not cleared after result");

    assert property (@(posedge clk) disable iff (!rst_n)
        best_reg != {1'b1, {(COORD_W-1){1'b0}}})
        else $error("kept distance out of range");

endmodule

`default_nettype wire
